// ----- hdl/slfr_pkg.sv -----
// slfr_pkg: shared widths, codes and types for the length-prefixed frame receiver
// used by the channel interfaces and by soh_length_frame_receiver
// no dependencies
package slfr_pkg;

    localparam int ByteW  = 8;
    localparam int LenW   = 16;
    localparam int TickW  = 16;
    localparam int KindW  = 2;
    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 16;

    localparam logic [ByteW-1:0] StartByteReset = 8'd1;
    localparam logic [TickW-1:0] TimeoutReset   = 16'd1000;

    // item kinds on the receive channel
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_START_BYTE = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_TIMEOUT    = 2'd1;

    typedef enum logic [KindW-1:0] {
        KIND_BYTE  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ABORT = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        PH_WAIT   = 4'b0001,
        PH_LEN_HI = 4'b0010,
        PH_LEN_LO = 4'b0100,
        PH_DATA   = 4'b1000
    } phase_t;

endpackage

// ----- hdl/slfr_if.sv -----
// slfr_if: valid/ready channel interfaces for the frame receiver
// receive items, result items and configuration writes
// depends on slfr_pkg
interface slfr_in_if
    import slfr_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             op;
    logic [ByteW-1:0] rx_byte;

    modport source(output valid, op, rx_byte, input ready);
    modport sink(input valid, op, rx_byte, output ready);
endinterface

interface slfr_out_if
    import slfr_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] data_byte;
    logic             last;
    logic [LenW-1:0]  packet_length;
    logic [LenW-1:0]  received_count;

    modport source(output valid, kind, data_byte, last, packet_length, received_count,
                   input ready);
    modport sink(input valid, kind, data_byte, last, packet_length, received_count,
                 output ready);
endinterface

interface slfr_cfg_if
    import slfr_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ----- hdl/soh_length_frame_receiver.sv -----
// soh_length_frame_receiver: start byte, 16-bit big-endian length, payload bytes
// with a packet timeout driven by tick items
// depends on slfr_pkg and the channel interfaces in slfr_if.sv
//
// usage
//   rx_item carries one item per handshake: a received uart byte (op 0) or a
//   time tick (op 1). result carries at most one item per received item:
//   a payload byte, an empty-packet completion or a timeout abort.
//   cfg writes start_byte (index 0) or timeout_ticks (index 1); it is always
//   ready, other indexes are dropped. write it only while the block is idle.
//   an item is captured in an input register, then decoded against the packet
//   state into a result register: result valid is registered and rises when
//   the item moves on from the input register. one item per cycle is sustained
//   while results are taken; the packet state is updated once per item.
//   if result is stalled with a result waiting, items that make no result
//   still flow; an item that makes a result holds in the input register and
//   rx_item.ready drops until the waiting result is taken.
//   reset puts the block in the wait-for-start state with the timer stopped,
//   start_byte 1 and timeout_ticks 1000.
module soh_length_frame_receiver
    import slfr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    slfr_in_if.sink      rx_item,
    slfr_out_if.source   result,
    slfr_cfg_if.sink     cfg
);

    // configuration
    logic [ByteW-1:0] start_byte_reg;
    logic [TickW-1:0] timeout_reg;

    // input register
    logic             in_valid_reg;
    logic             op_reg;
    logic [ByteW-1:0] byte_reg;

    // packet state
    phase_t           phase_reg, phase_next;
    logic [ByteW-1:0] length_high_reg, length_high_next;
    logic [LenW-1:0]  expected_reg, expected_next;
    logic [LenW-1:0]  count_reg, count_next;
    logic [TickW-1:0] ticks_reg, ticks_next;

    // result register
    logic             out_valid_reg;
    kind_t            kind_reg;
    logic [ByteW-1:0] data_reg;
    logic             last_reg;
    logic [LenW-1:0]  plen_reg;
    logic [LenW-1:0]  rcount_reg;

    logic             has_result;
    kind_t            res_kind;
    logic [ByteW-1:0] res_data;
    logic             res_last;
    logic [LenW-1:0]  count_inc;
    logic [LenW-1:0]  length_word;
    logic             advance;
    logic             in_take;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= StartByteReset;
            timeout_reg    <= TimeoutReset;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_START_BYTE)
            begin
                start_byte_reg <= cfg.data[ByteW-1:0];
            end
            else if (cfg.index == REG_TIMEOUT)
            begin
                timeout_reg <= cfg.data[TickW-1:0];
            end
        end
    end

    // an item moves on when its result has a free slot or it makes none
    assign advance  = in_valid_reg && (!out_valid_reg || result.ready || !has_result);
    assign rx_item.ready = !in_valid_reg || advance;
    assign in_take  = rx_item.valid && rx_item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx_item.ready)
        begin
            in_valid_reg <= rx_item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg   <= rx_item.op;
            byte_reg <= rx_item.rx_byte;
        end
    end

    assign count_inc   = count_reg + LenW'(1);
    assign length_word = {length_high_reg, byte_reg};

    always_comb
    begin
        phase_next       = phase_reg;
        length_high_next = length_high_reg;
        expected_next    = expected_reg;
        count_next       = count_reg;
        ticks_next       = ticks_reg;
        has_result       = 1'b0;
        res_kind         = KIND_BYTE;
        res_data         = '0;
        res_last         = 1'b0;

        if (op_reg == OP_TICK)
        begin
            if (phase_reg != PH_WAIT)
            begin
                // a loaded zero aborts on the first tick as one would
                if (ticks_reg <= TickW'(1))
                begin
                    phase_next = PH_WAIT;
                    ticks_next = '0;
                    has_result = 1'b1;
                    res_kind   = KIND_ABORT;
                    res_last   = 1'b1;
                end
                else
                begin
                    ticks_next = ticks_reg - TickW'(1);
                end
            end
        end
        else
        begin
            case (phase_reg)
                PH_WAIT:
                begin
                    if (byte_reg == start_byte_reg)
                    begin
                        phase_next       = PH_LEN_HI;
                        ticks_next       = timeout_reg;
                        length_high_next = '0;
                        expected_next    = '0;
                        count_next       = '0;
                    end
                end
                PH_LEN_HI:
                begin
                    length_high_next = byte_reg;
                    phase_next       = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    expected_next = length_word;
                    count_next    = '0;
                    if (length_word == '0)
                    begin
                        phase_next = PH_WAIT;
                        ticks_next = '0;
                        has_result = 1'b1;
                        res_kind   = KIND_EMPTY;
                        res_last   = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    count_next = count_inc;
                    has_result = 1'b1;
                    res_kind   = KIND_BYTE;
                    res_data   = byte_reg;
                    res_last   = (count_inc >= expected_reg);
                    if (count_inc >= expected_reg)
                    begin
                        phase_next = PH_WAIT;
                        ticks_next = '0;
                    end
                end
                default:
                begin
                    phase_next = PH_WAIT;
                    ticks_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_WAIT;
            length_high_reg <= '0;
            expected_reg    <= '0;
            count_reg       <= '0;
            ticks_reg       <= '0;
        end
        else if (advance)
        begin
            phase_reg       <= phase_next;
            length_high_reg <= length_high_next;
            expected_reg    <= expected_next;
            count_reg       <= count_next;
            ticks_reg       <= ticks_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
        begin
            kind_reg   <= res_kind;
            data_reg   <= res_data;
            last_reg   <= res_last;
            plen_reg   <= expected_next;
            rcount_reg <= count_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.kind           = kind_reg;
    assign result.data_byte      = data_reg;
    assign result.last           = last_reg;
    assign result.packet_length  = plen_reg;
    assign result.received_count = rcount_reg;

    // timer is stopped whenever no packet is open
    a_timer_stopped_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_WAIT |-> ticks_reg == '0)
        else $error("timer running while waiting for start byte");

    // payload phase never holds a finished packet
    a_count_below_length: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> count_reg < expected_reg)
        else $error("payload count reached length without completing");

    // a closing payload byte carries the full announced count
    a_last_byte_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == KIND_BYTE && last_reg
            |-> rcount_reg == plen_reg)
        else $error("last payload byte with count different from length");

    a_empty_counts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == KIND_EMPTY
            |-> plen_reg == '0 && rcount_reg == '0 && last_reg)
        else $error("empty packet result with nonzero counts");

    // a held item stays in the input register until it can move on
    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("input item lost while blocked");

endmodule

// ----- dv/frame_result_checker.sv -----
// frame_result_checker: watches the receive, result and config channels of the
// frame receiver, predicts every result item and compares it field by field
// depends on slfr_pkg and the channel interfaces in slfr_if.sv
module frame_result_checker
    import slfr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    slfr_in_if   rx_item,
    slfr_out_if  result,
    slfr_cfg_if  cfg,
    output int   mismatches,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        kind_t            kind;
        logic [ByteW-1:0] data_byte;
        logic             last;
        logic [LenW-1:0]  packet_length;
        logic [LenW-1:0]  received_count;
    } frame_result_t;

    frame_result_t    results_due[$];

    // register copies
    logic [ByteW-1:0] sof_byte;
    logic [TickW-1:0] tick_budget;

    // packet state
    phase_t           rx_phase;
    logic [ByteW-1:0] len_high;
    logic [LenW-1:0]  announced_len;
    logic [LenW-1:0]  payload_seen;
    logic [TickW-1:0] ticks_left;

    function automatic void queue_result(kind_t k, logic [ByteW-1:0] b, logic fin);
        frame_result_t r;
        r.kind           = k;
        r.data_byte      = b;
        r.last           = fin;
        r.packet_length  = announced_len;
        r.received_count = payload_seen;
        results_due.push_back(r);
    endfunction

    function automatic void decode_rx_item(logic op, logic [ByteW-1:0] b);
        logic fin;
        if (op == OP_TICK)
        begin
            // ticks only count down while a packet is open
            if (rx_phase != PH_WAIT)
            begin
                if (ticks_left <= 1)
                begin
                    rx_phase   = PH_WAIT;
                    ticks_left = '0;
                    queue_result(KIND_ABORT, '0, 1'b1);
                end
                else
                begin
                    ticks_left = ticks_left - 1'b1;
                end
            end
        end
        else
        begin
            case (rx_phase)
                PH_WAIT:
                begin
                    if (b == sof_byte)
                    begin
                        rx_phase      = PH_LEN_HI;
                        ticks_left    = tick_budget;
                        len_high      = '0;
                        announced_len = '0;
                        payload_seen  = '0;
                    end
                end
                PH_LEN_HI:
                begin
                    len_high = b;
                    rx_phase = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    announced_len = {len_high, b};
                    payload_seen  = '0;
                    if (announced_len == '0)
                    begin
                        rx_phase   = PH_WAIT;
                        ticks_left = '0;
                        queue_result(KIND_EMPTY, '0, 1'b1);
                    end
                    else
                    begin
                        rx_phase = PH_DATA;
                    end
                end
                default:
                begin
                    payload_seen = payload_seen + 1'b1;
                    fin = (payload_seen >= announced_len);
                    if (fin)
                    begin
                        rx_phase   = PH_WAIT;
                        ticks_left = '0;
                    end
                    queue_result(KIND_BYTE, b, fin);
                end
            endcase
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        frame_result_t got;
        frame_result_t want;
        if (!rst_n)
        begin
            sof_byte      = StartByteReset;
            tick_budget   = TimeoutReset;
            rx_phase      = PH_WAIT;
            len_high      = '0;
            announced_len = '0;
            payload_seen  = '0;
            ticks_left    = '0;
            results_due.delete();
            mismatches    = 0;
            outstanding   = 0;
        end
        else
        begin
            // results first: a result never belongs to the item accepted on the same edge
            if (result.valid && result.ready)
            begin
                got.kind           = kind_t'(result.kind);
                got.data_byte      = result.data_byte;
                got.last           = result.last;
                got.packet_length  = result.packet_length;
                got.received_count = result.received_count;
                if (results_due.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result kind=%0d data=%02h last=%0b len=%0d cnt=%0d",
                                 $realtime, got.kind, got.data_byte, got.last,
                                 got.packet_length, got.received_count);
                end
                else
                begin
                    want = results_due.pop_front();
                    if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                        got.last !== want.last || got.packet_length !== want.packet_length ||
                        got.received_count !== want.received_count)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  expected kind=%0d data=%02h last=%0b len=%0d cnt=%0d",
                                     want.kind, want.data_byte, want.last,
                                     want.packet_length, want.received_count);
                            $display("  actual   kind=%0d data=%02h last=%0b len=%0d cnt=%0d",
                                     got.kind, got.data_byte, got.last,
                                     got.packet_length, got.received_count);
                        end
                    end
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                // unknown indexes are dropped
                if (cfg.index == REG_START_BYTE)
                    sof_byte = cfg.data[ByteW-1:0];
                else if (cfg.index == REG_TIMEOUT)
                    tick_budget = cfg.data[TickW-1:0];
            end
            if (rx_item.valid && rx_item.ready)
                decode_rx_item(rx_item.op, rx_item.rx_byte);
            outstanding = results_due.size();
        end
    end

endmodule

// ----- dv/soh_length_frame_receiver_test.sv -----
// soh_length_frame_receiver_test: drives framed byte streams, ticks and register
// writes into the frame receiver; frame_result_checker predicts and compares
// depends on slfr_pkg, slfr_if.sv, the receiver and dv/frame_result_checker.sv
module soh_length_frame_receiver_test
    import slfr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;
    localparam int QuietLimit = 1000;
    localparam int PacketItems = 1300;

    logic clk;
    logic rst_n;

    slfr_in_if  rx_item();
    slfr_out_if result();
    slfr_cfg_if cfg();

    int mismatches;
    int outstanding;

    soh_length_frame_receiver dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx_item (rx_item),
        .result  (result),
        .cfg     (cfg)
    );

    frame_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_item     (rx_item),
        .result      (result),
        .cfg         (cfg),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    logic [ByteW-1:0] cur_start;
    logic [TickW-1:0] cur_timeout;
    int               tick_pct;
    int               pkt_items;
    int               phase_no;
    int               sink_stall;
    int               quiet_cycles;
    bit               src_burst;
    bit               sink_burst;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int pick_gap(input bit burst);
        return burst ? 0 : $urandom_range(0, 18);
    endfunction

    // caller sits on a falling edge; returns on the falling edge after acceptance
    task automatic send_item(input logic op, input logic [ByteW-1:0] b);
        int gap;
        if ($urandom_range(0, 39) == 0)
            src_burst = !src_burst;
        gap = pick_gap(src_burst);
        if (gap > 0)
        begin
            rx_item.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_item.valid   <= 1'b1;
        rx_item.op      <= op;
        rx_item.rx_byte <= b;
        do @(posedge clk); while (!rx_item.ready);
        pkt_items = pkt_items + 1;
        @(negedge clk);
    endtask

    task automatic send_packet(input logic [LenW-1:0] len, input int pct);
        send_item(OP_BYTE, cur_start);
        send_item(OP_BYTE, len[15:8]);
        send_item(OP_BYTE, len[7:0]);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < pct)
            begin
                send_item(OP_TICK, ByteW'($urandom_range(0, 255)));
            end
            send_item(OP_BYTE, ByteW'($urandom_range(0, 255)));
        end
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge clk); while (!cfg.ready);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // drain: every expected result taken, then room for in-flight items
    task automatic settle();
        rx_item.valid <= 1'b0;
        wait (outstanding == 0);
        repeat (4) @(negedge clk);
    endtask

    // result side: a random stall after each item taken
    initial
    begin
        result.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_stall > 0)
            begin
                result.ready <= 1'b0;
                sink_stall = sink_stall - 1;
            end
            else
            begin
                result.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (result.valid && result.ready)
        begin
            if ($urandom_range(0, 39) == 0)
                sink_burst = !sink_burst;
            sink_stall = pick_gap(sink_burst);
        end
    end

    always @(posedge clk)
    begin
        if ((rx_item.valid && rx_item.ready) || (result.valid && result.ready) ||
            (cfg.valid && cfg.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QuietLimit)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        rx_item.valid   = 1'b0;
        rx_item.op      = OP_BYTE;
        rx_item.rx_byte = '0;
        cfg.valid       = 1'b0;
        cfg.index       = REG_START_BYTE;
        cfg.data        = '0;
        cur_start       = StartByteReset;
        cur_timeout     = TimeoutReset;
        pkt_items       = 0;
        sink_stall      = 0;
        quiet_cycles    = 0;
        src_burst       = 1'b0;
        sink_burst      = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // idle noise: other bytes and ticks are dropped
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_TICK, 8'hA5);
        send_packet(16'd0, 0);
        // start byte value inside the payload is plain data
        send_item(OP_BYTE, cur_start);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'h02);
        send_item(OP_BYTE, cur_start);
        send_item(OP_BYTE, 8'hFF);
        settle();

        // shortest timeout: aborts in each packet phase
        cur_start   = 8'h00;
        cur_timeout = 16'd1;
        write_reg(REG_TIMEOUT, cur_timeout);
        write_reg(REG_START_BYTE, {8'h00, cur_start});
        write_reg(REG_UNUSED, 16'hFFFF);
        send_item(OP_BYTE, cur_start);
        send_item(OP_TICK, 8'h00);
        send_item(OP_BYTE, cur_start);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_TICK, 8'hFF);
        send_item(OP_BYTE, cur_start);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, 8'h80);
        send_item(OP_TICK, 8'h5A);
        settle();

        // one tick short of the timeout leaves the packet alive
        cur_timeout = 16'd2;
        write_reg(REG_TIMEOUT, cur_timeout);
        send_item(OP_BYTE, cur_start);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'h01);
        send_item(OP_TICK, 8'h00);
        send_item(OP_BYTE, 8'h7F);

        phase_no = 0;
        while (pkt_items < PacketItems)
        begin
            settle();
            case (phase_no)
                0:
                begin
                    cur_start   = 8'hFF;
                    cur_timeout = 16'hFFFF;
                    tick_pct    = 20;
                end
                1:
                begin
                    cur_start   = 8'h00;
                    cur_timeout = 16'd1;
                    tick_pct    = 3;
                end
                default:
                begin
                    cur_start = ByteW'($urandom_range(0, 255));
                    if ($urandom_range(0, 1) == 0)
                        cur_timeout = TickW'($urandom_range(2, 60));
                    else
                        cur_timeout = TickW'($urandom_range(1, 65535));
                    tick_pct = $urandom_range(0, 25);
                end
            endcase
            write_reg(REG_START_BYTE, {8'h00, cur_start});
            write_reg(REG_TIMEOUT, cur_timeout);
            if (phase_no == 2)
                write_reg(REG_UNUSED, CfgDataW'($urandom_range(0, 65535)));
            for (int k = 0; k < 20 && pkt_items < PacketItems; k++)
            begin
                repeat ($urandom_range(0, 2))
                    send_item(1'($urandom_range(0, 1)), ByteW'($urandom_range(0, 255)));
                case ($urandom_range(0, 19))
                    0, 1:
                        send_packet(16'd0, tick_pct);
                    2:
                    begin
                        // cut-off header or payload, later items land mid-packet
                        send_item(OP_BYTE, cur_start);
                        repeat ($urandom_range(0, 3))
                            send_item(OP_BYTE, ByteW'($urandom_range(0, 255)));
                    end
                    3, 4, 5:
                        send_packet(LenW'($urandom_range(9, 40)), tick_pct);
                    default:
                        send_packet(LenW'($urandom_range(1, 8)), tick_pct);
                endcase
            end
            phase_no = phase_no + 1;
        end

        settle();
        if (mismatches == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
